FILE: hdl/rgp_pkg.sv
// Shared widths, types and layout helpers for the RGB gradient pixel block.
package rgp_pkg;

   localparam int MAX_WIDTH_DEF = 4096;
   localparam int DEPTH_W       = 5;
   localparam logic [DEPTH_W-1:0] DEPTH_RESET = 5'd16;
   localparam int PIX_W   = 30;
   localparam int SPAN_W  = 13;
   localparam int IDX_W   = 12;
   localparam int CH_W    = 11;
   localparam int PROD_W  = IDX_W + CH_W;
   localparam int NUM_W   = PROD_W + 2;
   localparam int LANE_LAT = NUM_W + 2;
   localparam int REQ_DATA_W = 88;
   localparam int RSP_DATA_W = 32;

   typedef struct packed {
      logic [CH_W-1:0] s;
      logic [CH_W-1:0] e;
      logic [CH_W-1:0] mask;
   } chan_type;

   typedef struct packed {
      logic [3:0] k;
      logic [3:0] gbits;
      logic [4:0] roff;
   } layout_type;

   function automatic layout_type layout(input logic [DEPTH_W-1:0] d);
      logic [8:0] prod;
      logic [3:0] k;
      logic [4:0] r;
      layout_type l;
      prod = 9'(d) * 9'd11;
      k = prod[8:5];
      r = d - 5'({k, 1'b0} + {1'b0, k});
      l.k = k;
      l.gbits = k + ((r == 5'd1) ? 4'd1 : 4'd0);
      l.roff = 5'({k, 1'b0}) + r + ((r == 5'd2) ? 5'd1 : 5'd0);
      return l;
   endfunction

   function automatic logic [CH_W-1:0] low_mask(input logic [3:0] bits);
      logic [CH_W:0] m;
      m = (CH_W+1)'(1) << bits;
      return CH_W'(m - (CH_W+1)'(1));
   endfunction

endpackage

FILE: hdl/rgp_lane.sv
// One colour channel: step multiply, bit-per-stage divider, clamp.
module rgp_lane #(
   parameter int WW = 12
) (
   input  logic                      clock,
   input  logic                      en,
   input  rgp_pkg::chan_type         chan,
   input  logic [rgp_pkg::IDX_W-1:0] idx,
   input  logic [WW-1:0]             w1,
   input  logic                      one,
   output logic [rgp_pkg::CH_W-1:0]  res
);
   localparam int CW = rgp_pkg::CH_W;
   localparam int NW = rgp_pkg::NUM_W;
   localparam int PW = rgp_pkg::PROD_W;
   localparam int DW = WW + 1;

   logic [CW-1:0] s_ff [0:NW+1];
   logic [CW-1:0] m_ff [0:NW+1];
   logic          dir_ff [0:NW+1];
   logic          one_ff [0:NW+1];
   logic [PW-1:0] prod_ff;
   logic [WW-1:0] w1a_ff;
   logic [NW-1:0] num_ff [0:NW];
   logic [NW-1:0] q_ff [0:NW];
   logic [DW-1:0] rem_ff [0:NW];
   logic [DW-1:0] d_ff [0:NW];

   logic [CW-1:0] diff_in;
   logic          dir_in;
   assign dir_in  = chan.s >= chan.e;
   assign diff_in = dir_in ? (chan.s - chan.e) : (chan.e - chan.s);

   always_ff @(posedge clock) begin
      if (en) begin
         s_ff[0]   <= chan.s;
         m_ff[0]   <= chan.mask;
         dir_ff[0] <= dir_in;
         one_ff[0] <= one;
         prod_ff   <= PW'(idx) * PW'(diff_in);
         w1a_ff    <= w1;
         s_ff[1]   <= s_ff[0];
         m_ff[1]   <= m_ff[0];
         dir_ff[1] <= dir_ff[0];
         one_ff[1] <= one_ff[0];
         num_ff[0] <= {1'b0, prod_ff, 1'b0} + NW'(w1a_ff);
         d_ff[0]   <= {w1a_ff, 1'b0};
         rem_ff[0] <= '0;
         q_ff[0]   <= '0;
      end
   end

   for (genvar i = 1; i <= NW; i++) begin : g_div
      logic [DW:0] trial;
      logic        ge;
      assign trial = {rem_ff[i-1], num_ff[i-1][NW-1]};
      assign ge    = trial >= {1'b0, d_ff[i-1]};
      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[i]   <= ge ? DW'(trial - {1'b0, d_ff[i-1]}) : DW'(trial);
            q_ff[i]     <= {q_ff[i-1][NW-2:0], ge};
            num_ff[i]   <= {num_ff[i-1][NW-2:0], 1'b0};
            d_ff[i]     <= d_ff[i-1];
            s_ff[i+1]   <= s_ff[i];
            m_ff[i+1]   <= m_ff[i];
            dir_ff[i+1] <= dir_ff[i];
            one_ff[i+1] <= one_ff[i];
         end
      end
   end

   logic [NW-1:0] mag;
   logic [NW-1:0] s_x;
   logic [NW-1:0] head;
   assign mag  = q_ff[NW];
   assign s_x  = NW'(s_ff[NW+1]);
   assign head = NW'(m_ff[NW+1] - s_ff[NW+1]);

   always_comb begin
      if (one_ff[NW+1]) begin
         res = s_ff[NW+1];
      end else if (dir_ff[NW+1]) begin
         res = (mag > s_x) ? '0 : CW'(s_x - mag);
      end else begin
         res = (mag > head) ? m_ff[NW+1] : CW'(s_x + mag);
      end
   end
endmodule

FILE: hdl/rgb_gradient_pixel_top.sv
// Top level of the RGB gradient pixel block: unpack, three lanes, pack.
//
//  channel  dir  fields (lsb up)
//  req_     in   start_colour, end_colour, span_width, pixel_index
//  rsp_     out  pixel
//  csr_     in   pixel depth
//
// One word per cycle sustained while rsp_ is not stalled; stages are unpack,
// multiply, setup, a 25-bit divider (one quotient bit per stage) and output.
// Synchronous reset clears valids and sets depth to 16.
// A stall on rsp_ freezes the whole pipeline; nothing is dropped.
module rgb_gradient_pixel_top #(
   parameter int MAX_WIDTH = rgp_pkg::MAX_WIDTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // start_colour[29:0], end_colour[59:30], span_width[72:60], pixel_index[84:73]
   input  logic [rgp_pkg::REQ_DATA_W-1:0] req_tdata,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // pixel[29:0]
   output logic [rgp_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [rgp_pkg::DEPTH_W-1:0]    csr_data
);
   localparam int WW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int CW  = rgp_pkg::CH_W;
   localparam int PXW = rgp_pkg::PIX_W;
   localparam int LAT = rgp_pkg::LANE_LAT;

   logic [rgp_pkg::DEPTH_W-1:0] depth_ff;
   logic                        v0_ff;
   logic                        vp_ff [1:LAT];
   logic                        out_v_ff;
   logic [PXW-1:0]              pix_ff;
   rgp_pkg::chan_type           ch_ff [0:2];
   logic [rgp_pkg::IDX_W-1:0]   idx_ff;
   logic [WW-1:0]               w1_ff;
   logic                        one_ff;
   logic                        en;

   assign csr_ready  = 1'b1;
   assign en         = !out_v_ff || rsp_tready;
   assign req_tready = en;
   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = {{(rgp_pkg::RSP_DATA_W-PXW){1'b0}}, pix_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff <= rgp_pkg::DEPTH_RESET;
      end else if (csr_valid) begin
         depth_ff <= csr_data;
      end
   end

   rgp_pkg::layout_type lay;
   logic [CW-1:0]  cmask, gmask;
   logic [PXW-1:0] a_in, b_in, a_r, b_r, a_g, b_g;
   logic [31:0]    span_x;
   logic [31:0]    span_s;

   assign lay   = rgp_pkg::layout(depth_ff);
   assign cmask = rgp_pkg::low_mask(lay.k);
   assign gmask = rgp_pkg::low_mask(lay.gbits);
   assign a_in  = req_tdata[29:0];
   assign b_in  = req_tdata[59:30];
   assign a_r   = a_in >> lay.roff;
   assign b_r   = b_in >> lay.roff;
   assign a_g   = a_in >> lay.k;
   assign b_g   = b_in >> lay.k;
   assign span_x = 32'(req_tdata[72:60]);

   always_comb begin
      span_s = span_x;
      if (span_x == 32'd0) begin
         span_s = 32'd1;
      end else if (span_x > 32'(MAX_WIDTH)) begin
         span_s = 32'(MAX_WIDTH);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         for (int i = 1; i <= LAT; i++) begin
            vp_ff[i] <= 1'b0;
         end
         out_v_ff <= 1'b0;
      end else if (en) begin
         v0_ff <= req_tvalid;
         vp_ff[1] <= v0_ff;
         for (int i = 2; i <= LAT; i++) begin
            vp_ff[i] <= vp_ff[i-1];
         end
         out_v_ff <= vp_ff[LAT];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ch_ff[2].s    <= a_r[CW-1:0] & cmask;
         ch_ff[2].e    <= b_r[CW-1:0] & cmask;
         ch_ff[2].mask <= cmask;
         ch_ff[1].s    <= a_g[CW-1:0] & gmask;
         ch_ff[1].e    <= b_g[CW-1:0] & gmask;
         ch_ff[1].mask <= gmask;
         ch_ff[0].s    <= a_in[CW-1:0] & cmask;
         ch_ff[0].e    <= b_in[CW-1:0] & cmask;
         ch_ff[0].mask <= cmask;
         idx_ff        <= req_tdata[84:73];
         w1_ff         <= WW'(span_s - 32'd1);
         one_ff        <= span_s == 32'd1;
      end
   end

   logic [CW-1:0] res [0:2];
   for (genvar c = 0; c < 3; c++) begin : g_lane
      rgp_lane #(.WW(WW)) u_lane (
         .clock (clock),
         .en    (en),
         .chan  (ch_ff[c]),
         .idx   (idx_ff),
         .w1    (w1_ff),
         .one   (one_ff),
         .res   (res[c])
      );
   end

   logic [PXW-1:0] pix_in;
   assign pix_in = (PXW'(res[2]) << lay.roff) | (PXW'(res[1]) << lay.k) | PXW'(res[0]);

   always_ff @(posedge clock) begin
      if (en) begin
         pix_ff <= pix_in;
      end
   end
endmodule
